/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property check that is switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property check that is evaluated at every rising clock edge.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK_RST(label, clk, rst, prop, msg)
`define ASSERT_CLK(label, clk, prop, msg)

`endif

`endif

/* sv/chacha_pkg.sv */
// ----------------------------------------------------------------------------
// ChaCha20 block function package
// Shared types, constants and the half-quarter-round helper.
// ----------------------------------------------------------------------------
package chacha_pkg;

   // Sizes of the block state and the round schedule.
   localparam int unsigned NUM_WORDS  = 16;
   localparam int unsigned NUM_LANES  = 4;
   localparam int unsigned NUM_KEYS   = 4;
   localparam int unsigned ROUNDS     = 20;
   localparam int unsigned ROUND_W    = 5;
   localparam int unsigned IDX_W      = 4;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 64;

   localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);
   localparam logic [IDX_W-1:0]   LAST_WORD  = IDX_W'(NUM_WORDS - 1);

   typedef logic [31:0] word_type;

   // The four fixed words "expand 32-byte k".
   localparam word_type SIGMA [NUM_LANES] = '{
      32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
   };

   // Input word: block counter and nonce.
   typedef struct packed {
      logic [31:0] block_counter;
      logic [31:0] nonce_word_0;
      logic [31:0] nonce_word_1;
      logic [31:0] nonce_word_2;
   } req_word_type;

   // Result word: one keystream word with its position.
   typedef struct packed {
      logic [31:0]      keystream_word;
      logic [IDX_W-1:0] word_index;
      logic             last_word;
   } rsp_word_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FINAL,
      ST_EMIT
   } cc_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             load;
      logic             round;
      logic             second_half;
      logic             diagonal;
      logic             finalize;
      logic             emit;
      logic [IDX_W-1:0] word_index;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } dp_status_type;

   // The four words that one quarter round works on.
   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
   } quad_type;

   // Half a quarter round: two add, xor, rotate steps. The first half rotates
   // by 16 and 12, the second half by 8 and 7.
   function automatic quad_type qr_half(input quad_type q, input logic second);
      quad_type r;
      word_type dx;
      word_type bx;
      r.a = q.a + q.b;
      dx  = q.d ^ r.a;
      r.d = second ? {dx[23:0], dx[31:24]} : {dx[15:0], dx[31:16]};
      r.c = q.c + r.d;
      bx  = q.b ^ r.c;
      r.b = second ? {bx[24:0], bx[31:25]} : {bx[19:0], bx[31:20]};
      return r;
   endfunction

endpackage

/* sv/chacha_ctrl.sv */
// ----------------------------------------------------------------------------
// ChaCha20 controller
// Sequences state load, twenty rounds in half-quarter-round steps, the final
// addition and the emission of sixteen words.
// ----------------------------------------------------------------------------
module chacha_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  chacha_pkg::dp_status_type status,
   output chacha_pkg::dp_cmd_type    cmd
);

   chacha_pkg::cc_state_type state_ff, state_in;
   logic [chacha_pkg::ROUND_W-1:0] round_ff, round_in;
   logic                           half_ff, half_in;
   logic [chacha_pkg::IDX_W-1:0]   idx_ff, idx_in;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= chacha_pkg::ST_IDLE;
         round_ff <= '0;
         half_ff  <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         half_ff  <= half_in;
         idx_ff   <= idx_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         chacha_pkg::ST_IDLE: begin
            if (req_valid) state_in = chacha_pkg::ST_ROUND;
         end
         chacha_pkg::ST_ROUND: begin
            if (half_ff && round_ff == chacha_pkg::LAST_ROUND) begin
               state_in = chacha_pkg::ST_FINAL;
            end
         end
         chacha_pkg::ST_FINAL: begin
            state_in = chacha_pkg::ST_EMIT;
         end
         chacha_pkg::ST_EMIT: begin
            if (status.out_free && idx_ff == chacha_pkg::LAST_WORD) begin
               state_in = chacha_pkg::ST_IDLE;
            end
         end
      endcase
   end

   // Round and word counters.
   always_comb begin
      round_in = round_ff;
      half_in  = half_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         chacha_pkg::ST_ROUND: begin
            half_in = ~half_ff;
            if (half_ff) begin
               round_in = (round_ff == chacha_pkg::LAST_ROUND) ? '0 : round_ff + 1'b1;
            end
         end
         chacha_pkg::ST_EMIT: begin
            if (status.out_free) idx_in = idx_ff + 1'b1;
         end
         default: begin
            round_in = '0;
            half_in  = 1'b0;
            idx_in   = '0;
         end
      endcase
   end

   // Outputs: commands to the datapath and the input stall.
   always_comb begin
      req_stall        = (state_ff != chacha_pkg::ST_IDLE);
      cmd.load         = (state_ff == chacha_pkg::ST_IDLE) && req_valid;
      cmd.round        = (state_ff == chacha_pkg::ST_ROUND);
      cmd.second_half  = half_ff;
      cmd.diagonal     = round_ff[0];
      cmd.finalize     = (state_ff == chacha_pkg::ST_FINAL);
      cmd.emit         = (state_ff == chacha_pkg::ST_EMIT) && status.out_free;
      cmd.word_index   = idx_ff;
   end

endmodule

/* sv/chacha_dp.sv */
// ----------------------------------------------------------------------------
// ChaCha20 datapath
// Key registers, working state, saved input state, a four-lane round unit
// and the result register.
// ----------------------------------------------------------------------------
module chacha_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  chacha_pkg::req_word_type            req_payload,
   input  logic                                csr_write_en,
   input  logic [chacha_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [chacha_pkg::CSR_DATA_W-1:0]   csr_data,
   input  chacha_pkg::dp_cmd_type              cmd,
   output chacha_pkg::dp_status_type           status,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output chacha_pkg::rsp_word_type            rsp_payload
);

   logic [chacha_pkg::CSR_DATA_W-1:0] key_ff [chacha_pkg::NUM_KEYS];
   logic [chacha_pkg::CSR_DATA_W-1:0] key_in [chacha_pkg::NUM_KEYS];
   chacha_pkg::word_type w_ff    [chacha_pkg::NUM_WORDS];
   chacha_pkg::word_type w_in    [chacha_pkg::NUM_WORDS];
   chacha_pkg::word_type copy_ff [chacha_pkg::NUM_WORDS];
   chacha_pkg::word_type copy_in [chacha_pkg::NUM_WORDS];
   chacha_pkg::word_type init_w  [chacha_pkg::NUM_WORDS];
   chacha_pkg::word_type col_w   [chacha_pkg::NUM_WORDS];
   chacha_pkg::word_type diag_w  [chacha_pkg::NUM_WORDS];
   logic                         rsp_valid_ff, rsp_valid_in;
   chacha_pkg::rsp_word_type     rsp_word_ff, rsp_word_in;

   // Key registers, written through the configuration port.
   always_comb begin
      key_in = key_ff;
      if (csr_write_en) key_in[csr_index] = csr_data;
   end

   // Input state built from the constants, the key and the input word.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         init_w[i]         = chacha_pkg::SIGMA[i];
         init_w[4 + 2 * i] = key_ff[i][31:0];
         init_w[5 + 2 * i] = key_ff[i][63:32];
      end
      init_w[12] = req_payload.block_counter;
      init_w[13] = req_payload.nonce_word_0;
      init_w[14] = req_payload.nonce_word_1;
      init_w[15] = req_payload.nonce_word_2;
   end

   // Round unit: four lanes, each doing half a quarter round per cycle, on
   // the columns or on the diagonals.
   always_comb begin
      chacha_pkg::quad_type qc;
      chacha_pkg::quad_type qd;
      col_w  = w_ff;
      diag_w = w_ff;
      for (int l = 0; l < 4; l++) begin
         qc = chacha_pkg::qr_half({w_ff[l], w_ff[4 + l], w_ff[8 + l], w_ff[12 + l]},
                                  cmd.second_half);
         col_w[l]      = qc.a;
         col_w[4 + l]  = qc.b;
         col_w[8 + l]  = qc.c;
         col_w[12 + l] = qc.d;
         qd = chacha_pkg::qr_half({w_ff[l], w_ff[4 + ((l + 1) & 3)],
                                   w_ff[8 + ((l + 2) & 3)], w_ff[12 + ((l + 3) & 3)]},
                                  cmd.second_half);
         diag_w[l]                   = qd.a;
         diag_w[4 + ((l + 1) & 3)]   = qd.b;
         diag_w[8 + ((l + 2) & 3)]   = qd.c;
         diag_w[12 + ((l + 3) & 3)]  = qd.d;
      end
   end

   // Working state: load, round step, final addition or shift toward word 0.
   always_comb begin
      w_in    = w_ff;
      copy_in = copy_ff;
      unique if (cmd.load) begin
         w_in    = init_w;
         copy_in = init_w;
      end else if (cmd.round) begin
         w_in = cmd.diagonal ? diag_w : col_w;
      end else if (cmd.finalize) begin
         for (int i = 0; i < chacha_pkg::NUM_WORDS; i++) begin
            w_in[i] = w_ff[i] + copy_ff[i];
         end
      end else if (cmd.emit) begin
         for (int i = 0; i < chacha_pkg::NUM_WORDS - 1; i++) begin
            w_in[i] = w_ff[i + 1];
         end
      end else begin
         w_in = w_ff;
      end
   end

   // Result register: loads a word when it is empty or being taken.
   always_comb begin
      status.out_free = !rsp_valid_ff || !rsp_stall;
      rsp_word_in     = rsp_word_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      if (cmd.emit) begin
         rsp_valid_in               = 1'b1;
         rsp_word_in.keystream_word = w_ff[0];
         rsp_word_in.word_index     = cmd.word_index;
         rsp_word_in.last_word      = (cmd.word_index == chacha_pkg::LAST_WORD);
      end
   end

   // Control and key registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < chacha_pkg::NUM_KEYS; k++) key_ff[k] <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         key_ff       <= key_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      w_ff        <= w_in;
      copy_ff     <= copy_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_word_ff;

endmodule

/* sv/chacha20_block_function.sv */
// ----------------------------------------------------------------------------
// ChaCha20 block function
// Turns a block counter and nonce into sixteen 32-bit keystream words under
// the key held in four 64-bit configuration registers.
// ----------------------------------------------------------------------------
//   Channel   Direction  Word                            Handshake
//   req_      in         block counter, three nonce words valid / stall
//   rsp_      out        keystream word, index, last flag valid / stall
//   csr_      in         key register index and data      write enable
//
// After acceptance a block passes through the round steps, the final addition
// and the emission of its 16 words through the result register. The round
// unit does half a quarter round on four lanes per cycle, so each of the 20
// rounds is done in two halves. A new word is taken only while idle. Output
// stalls hold the emission word by word.
// Reset clears the key to zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chacha20_block_function (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  chacha_pkg::req_word_type          req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output chacha_pkg::rsp_word_type          rsp_payload,
   input  logic                              csr_write_en,
   input  logic [chacha_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [chacha_pkg::CSR_DATA_W-1:0] csr_data
);

   chacha_pkg::dp_cmd_type    cmd;
   chacha_pkg::dp_status_type status;

   // Sequencer.
   chacha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // State, round unit and result register.
   chacha_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_payload  (req_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

   // An accepted word keeps the input stalled while the block is worked on.
   `ASSERT_CLK_RST(a_busy_after_accept, clock, reset, req_valid && !req_stall |=> req_stall, "input not stalled after accept")

   // Words of one block follow each other with rising index.
   `ASSERT_CLK_RST(a_index_steps, clock, reset, rsp_valid && !rsp_stall && !rsp_payload.last_word |=> rsp_valid && rsp_payload.word_index == $past(rsp_payload.word_index) + 4'd1, "word index did not step")

   // After the last word no result can be ready in the next cycle.
   `ASSERT_CLK_RST(a_gap_after_last, clock, reset, rsp_valid && !rsp_stall && rsp_payload.last_word |=> !rsp_valid, "result right after last word")

   // The last flag marks exactly the final word of the block.
   `ASSERT_CLK_RST(a_last_flag, clock, reset, rsp_valid |-> rsp_payload.last_word == (rsp_payload.word_index == chacha_pkg::LAST_WORD), "last flag and index disagree")

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// ChaCha20 block function testbench
// Sends block counter and nonce words under several keys and checks every
// keystream word against a software model of the block function. Both sides
// stall at random, with one long output hold-off and one drained pause.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int HOLD_CYCLES    = 300;
   localparam int CFG_SETTLE     = 8;
   localparam int END_SETTLE     = 64;
   localparam int RANDOM_PHASES  = 4;
   localparam int PHASE_WORDS    = 40;
   localparam int MAX_REPORTS    = 10;

   // Key register indexes on the configuration port.
   typedef enum logic [chacha_pkg::CSR_IDX_W-1:0] {
      KEY_REG_01,
      KEY_REG_23,
      KEY_REG_45,
      KEY_REG_67
   } key_reg_type;

   // Holds the key, predicts each keystream block and checks the results.
   class keystream_scoreboard;
      bit [31:0]                key_words [8];
      bit [31:0]                mix_state [16];
      chacha_pkg::rsp_word_type keystream_q [$];
      int                       errors;

      function void set_key(int idx, bit [63:0] value);
         key_words[2 * idx]     = value[31:0];
         key_words[2 * idx + 1] = value[63:32];
      endfunction

      function bit [31:0] rotl(bit [31:0] v, int n);
         return (v << n) | (v >> (32 - n));
      endfunction

      function void quarter_round(int a, int b, int c, int d);
         mix_state[a] += mix_state[b]; mix_state[d] = rotl(mix_state[d] ^ mix_state[a], 16);
         mix_state[c] += mix_state[d]; mix_state[b] = rotl(mix_state[b] ^ mix_state[c], 12);
         mix_state[a] += mix_state[b]; mix_state[d] = rotl(mix_state[d] ^ mix_state[a], 8);
         mix_state[c] += mix_state[d]; mix_state[b] = rotl(mix_state[b] ^ mix_state[c], 7);
      endfunction

      // Builds the input state, runs ten double rounds and queues the 16 words.
      function void note_block_request(chacha_pkg::req_word_type w);
         bit [31:0]                start_state [16];
         chacha_pkg::rsp_word_type e;
         int                       i;
         start_state[0] = 32'h61707865;
         start_state[1] = 32'h3320646e;
         start_state[2] = 32'h79622d32;
         start_state[3] = 32'h6b206574;
         for (i = 0; i < 8; i++) start_state[4 + i] = key_words[i];
         start_state[12] = w.block_counter;
         start_state[13] = w.nonce_word_0;
         start_state[14] = w.nonce_word_1;
         start_state[15] = w.nonce_word_2;
         mix_state = start_state;
         repeat (10) begin
            quarter_round(0, 4, 8, 12);
            quarter_round(1, 5, 9, 13);
            quarter_round(2, 6, 10, 14);
            quarter_round(3, 7, 11, 15);
            quarter_round(0, 5, 10, 15);
            quarter_round(1, 6, 11, 12);
            quarter_round(2, 7, 8, 13);
            quarter_round(3, 4, 9, 14);
         end
         for (i = 0; i < 16; i++) begin
            e.keystream_word = mix_state[i] + start_state[i];
            e.word_index     = i[chacha_pkg::IDX_W-1:0];
            e.last_word      = (i == 15);
            keystream_q.push_back(e);
         end
      endfunction

      // Compares one accepted result word with the oldest expected word.
      function void check_keystream_word(chacha_pkg::rsp_word_type got);
         chacha_pkg::rsp_word_type e;
         if (keystream_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected word: keystream %h index %0d last %0b",
                        got.keystream_word, got.word_index, got.last_word);
            return;
         end
         e = keystream_q.pop_front();
         if (got.keystream_word !== e.keystream_word || got.word_index !== e.word_index ||
             got.last_word !== e.last_word) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                        e.keystream_word, e.word_index, e.last_word,
                        got.keystream_word, got.word_index, got.last_word);
         end
      endfunction

      function int pending();
         return keystream_q.size();
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   chacha_pkg::req_word_type          req_payload;
   logic                              rsp_valid;
   logic                              rsp_stall;
   chacha_pkg::rsp_word_type          rsp_payload;
   logic                              csr_write_en;
   logic [chacha_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [chacha_pkg::CSR_DATA_W-1:0] csr_data;

   keystream_scoreboard sb;
   bit quiet_mode;
   bit hold_req;
   int hold_left;

   chacha20_block_function u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // Free-running clock.
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Watchdog on the whole run.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb_top: done, errors");
      $finish;
   end

   // Both channels are observed at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_block_request(req_payload);
         if (rsp_valid && !rsp_stall) sb.check_keystream_word(rsp_payload);
      end
   end

   // Result side stall: random idling, none in quiet mode, or a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_req) begin
         hold_req  = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (quiet_mode) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 8);
      end
   end

   // Writes one key register and tells the scoreboard.
   task automatic write_key(input key_reg_type idx,
                            input logic [chacha_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
      sb.set_key(int'(idx), value);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic load_key(input bit [63:0] k01, input bit [63:0] k23,
                           input bit [63:0] k45, input bit [63:0] k67);
      write_key(KEY_REG_01, k01);
      write_key(KEY_REG_23, k23);
      write_key(KEY_REG_45, k45);
      write_key(KEY_REG_67, k67);
   endtask

   // Offers one word and returns once it has been accepted.
   task automatic drive_word(input chacha_pkg::req_word_type w);
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= w;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_gap(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Stops sending and waits until every expected word has come back.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (CFG_SETTLE) @(posedge clock);
   endtask

   // Field values lean toward the extremes now and then.
   function automatic bit [31:0] random_field();
      int pick;
      pick = $urandom_range(15);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return $urandom;
   endfunction

   function automatic chacha_pkg::req_word_type random_word();
      chacha_pkg::req_word_type w;
      w.block_counter = random_field();
      w.nonce_word_0  = random_field();
      w.nonce_word_1  = random_field();
      w.nonce_word_2  = random_field();
      return w;
   endfunction

   // Main sequence: directed keys and words, then random phases.
   initial begin
      int phase;
      int n;
      sb           = new();
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      rsp_stall    = 1'b0;
      csr_write_en = 1'b0;
      csr_index    = KEY_REG_01;
      csr_data     = '0;
      quiet_mode   = 1'b0;
      hold_req     = 1'b0;
      hold_left    = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Standard test key with the standard counter and nonce, then edge words.
      load_key(64'h07060504_03020100, 64'h0f0e0d0c_0b0a0908,
               64'h17161514_13121110, 64'h1f1e1d1c_1b1a1918);
      drive_word('{block_counter: 32'h1, nonce_word_0: 32'h09000000,
                   nonce_word_1: 32'h4a000000, nonce_word_2: 32'h0});
      drive_word('{32'h0, 32'h0, 32'h0, 32'h0});
      drive_word('{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff});
      drive_word('{32'hffffffff, 32'h0, 32'h0, 32'h0});
      drive_word('{32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555});
      drain_results();

      // All-zero key.
      load_key('0, '0, '0, '0);
      drive_word('{32'h0, 32'h0, 32'h0, 32'h0});
      drive_word('{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff});
      drive_word('{32'hffffffff, 32'h1, 32'h0, 32'h80000000});
      drain_results();

      // All-ones key.
      load_key('1, '1, '1, '1);
      drive_word('{32'h0, 32'h0, 32'h0, 32'h0});
      drive_word('{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff});
      drive_word('{32'hffffffff, 32'h0, 32'h0, 32'h0});
      drive_word('{32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa});
      drain_results();

      // Random keys and words. The first phase runs without any idling.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         quiet_mode = (phase == 0);
         load_key({$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
         for (n = 0; n < PHASE_WORDS; n++) begin
            if (!quiet_mode && $urandom_range(99) < 8) idle_gap($urandom_range(1, 8));
            drive_word(random_word());
            if (phase == 1 && n == 8) hold_req = 1'b1;
            if (phase == 2 && n == 20) drain_results();
         end
         drain_results();
      end

      repeat (END_SETTLE) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

/* chacha20_block_function.f */
+incdir+sv
sv/chacha_pkg.sv
sv/chacha_ctrl.sv
sv/chacha_dp.sv
sv/chacha20_block_function.sv
tb/tb_top.sv
